// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ----- hdl/shab_pkg.sv -----
package shab_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } shab_state_t;

  typedef struct packed {
    logic put_data;    // write the input byte
    logic put_pad;     // write a padding or length byte
    logic start_block; // load working variables
    logic do_round;    // run one round
    logic do_fold;     // add working vars into chain
    logic reinit;      // back to initial state
    logic shift_out;   // advance output word
  } shab_cmd_t;

  typedef struct packed {
    logic block_full; // fill index at 63 before this write
    logic last_round;
    logic len_done;   // a pad write now stores the last length byte
  } shab_stat_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,32'h923f82a4,
    32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,32'h72be5d74,32'h80deb1fe,
    32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,
    32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
    32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,
    32'h53380d13,32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,32'h19a4c116,
    32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
    32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,32'h90befffa,32'ha4506ceb,32'hbef9a3f7,
    32'hc67178f2};

  localparam logic [7:0] PAD_MARK = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ----- hdl/shab_if.sv -----
interface shab_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface shab_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        final_word;
  modport source (output valid, digest_word, word_index, final_word, input ready);
  modport sink (input valid, digest_word, word_index, final_word, output ready);
endinterface

// ----- hdl/shab_datapath.sv -----
module shab_datapath
  import shab_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  shab_cmd_t   cmd,
  input  logic [7:0]  in_byte,
  output shab_stat_t  stat,
  output logic [31:0] word_out,
  output logic [2:0]  word_idx
);
  `include "assert_macros.svh"

  logic [31:0] blk_r [16];
  logic [31:0] w_r [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [63:0] bits_r;
  logic [6:0]  fill_r;
  logic [5:0]  rnd_r;
  logic [2:0]  oidx_r;
  logic [7:0]  pad_byte;
  logic [7:0]  wr_byte;
  logic [31:0] t1, t2, s0, s1, w_new;
  logic [31:0] k_w;
  logic        mark_r; // marker byte not yet written
  logic        zero_r; // marker landed past 55: rest of this block is zeros

  // padding byte by position: zeros, then big-endian length in the last eight bytes
  always_comb begin
    if (fill_r[5:0] >= 6'd56 && !zero_r) pad_byte = bits_r[8*(63 - fill_r[5:0]) +: 8];
    else pad_byte = 8'd0;
  end

  assign wr_byte = cmd.put_data ? in_byte : (mark_r ? PAD_MARK : pad_byte);

  assign stat = '{block_full: (fill_r == 7'd63),
                  last_round: (rnd_r == 6'd63),
                  len_done:   (fill_r == 7'd63) && !mark_r && !zero_r};

  always_comb begin
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    k_w = ROUND_K[rnd_r] + w_r[0];
    t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + k_w;
    t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (cmd.put_data || cmd.put_pad)
      blk_r[fill_r[5:2]][8*(3 - fill_r[1:0]) +: 8] <= wr_byte;
    if (cmd.start_block) begin
      // the closing byte is written on this same edge: take it from the write path
      for (int i = 0; i < 15; i++) w_r[i] <= blk_r[i];
      w_r[15] <= {blk_r[15][31:8], wr_byte};
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.do_round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
      bits_r <= '0;
      fill_r <= '0;
      rnd_r  <= '0;
      oidx_r <= '0;
      mark_r <= 1'b1;
      zero_r <= 1'b0;
    end else if (cmd.reinit) begin
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
      bits_r <= '0;
      fill_r <= '0;
      oidx_r <= '0;
      mark_r <= 1'b1;
      zero_r <= 1'b0;
    end else begin
      if (cmd.put_data) bits_r <= bits_r + 64'd8;
      if (cmd.put_pad) begin
        mark_r <= 1'b0;
        if (fill_r == 7'd63) zero_r <= 1'b0;
        else if (mark_r && fill_r[5:0] >= 6'd56) zero_r <= 1'b1;
      end
      if (cmd.put_data || cmd.put_pad) fill_r <= (fill_r == 7'd63) ? 7'd0 : fill_r + 7'd1;
      if (cmd.start_block) rnd_r <= '0;
      else if (cmd.do_round) rnd_r <= rnd_r + 6'd1;
      if (cmd.do_fold)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      if (cmd.shift_out) oidx_r <= oidx_r + 3'd1;
    end
  end

  assign word_out = h_r[oidx_r];
  assign word_idx = oidx_r;

  `ASSERT_ALWAYS(a_fill_range, clk, rst_n, fill_r < 7'd64, "fill index out of range")
  `ASSERT_IMPL(a_round_step, clk, rst_n, cmd.do_round && !cmd.start_block,
    ##1 (rnd_r == $past(rnd_r) + 6'd1), "round counter did not advance")
  `ASSERT_IMPL(a_no_mix, clk, rst_n, cmd.do_round, !(cmd.put_data || cmd.put_pad),
    "byte write during rounds")
endmodule

// ----- hdl/shab_ctrl.sv -----
module shab_ctrl
  import shab_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_has_byte,
  input  logic       in_end,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  logic [2:0] word_idx,
  input  shab_stat_t stat,
  output shab_cmd_t  cmd
);
  `include "assert_macros.svh"

  shab_state_t state_r, state_nxt;
  logic        fin_r, fin_nxt; // finalizing current message
  logic        done_r;         // length block written, digest ready after its fold
  logic        acc;
  logic        pad_full;

  assign acc = in_valid && in_ready;
  assign pad_full = stat.block_full;

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          fin_nxt = in_end;
          if (in_has_byte && stat.block_full) state_nxt = ST_ROUND;
          else if (in_end) state_nxt = ST_PAD;
        end
      end
      ST_ROUND: if (stat.last_round) state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (!fin_r) state_nxt = ST_IDLE;
        else if (done_r) state_nxt = ST_EMIT;
        else state_nxt = ST_PAD;
      end
      ST_PAD: if (pad_full) state_nxt = ST_ROUND;
      ST_EMIT: if (out_ready && word_idx == 3'd7) begin
        state_nxt = ST_IDLE;
        fin_nxt = 1'b0;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fin_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      if (state_r == ST_EMIT) done_r <= 1'b0;
      else if (cmd.put_pad && stat.len_done) done_r <= 1'b1;
    end
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.put_data = acc && in_has_byte;
        cmd.start_block = acc && in_has_byte && stat.block_full;
      end
      ST_ROUND: cmd.do_round = 1'b1;
      ST_FOLD:  cmd.do_fold = 1'b1;
      ST_PAD: begin
        cmd.put_pad = 1'b1;
        cmd.start_block = stat.block_full;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.shift_out = out_ready;
        cmd.reinit = out_ready && word_idx == 3'd7;
      end
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_out_only_emit, clk, rst_n, out_valid, state_r == ST_EMIT,
    "output valid outside emit")
  `ASSERT_IMPL(a_fold_after_round, clk, rst_n, state_r == ST_FOLD,
    $past(state_r) == ST_ROUND, "fold without rounds")
endmodule

// ----- hdl/sha256_byte_stream_hasher_unit.sv -----
// A byte that does not fill a block is only written into the buffer; one that fills it also
// loads the rounds as it is accepted, then 64 rounds and one fold run before the next byte.
// End of message: padding one byte per cycle to the end of the block, then 64 rounds and
// one fold per final block (one or two), then eight digest beats, one per cycle with out_ready.
// One item at a time. Synchronous active-low reset loads the initial hash and clears counts.
module sha256_byte_stream_hasher_unit
  import shab_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  shab_in_if.sink    in_ch,
  shab_out_if.source out_ch
);

  shab_cmd_t   cmd;
  shab_stat_t  stat;
  logic [31:0] word;
  logic [2:0]  idx;

  // Controller sequences absorb, rounds, fold, padding and emit.
  shab_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_has_byte(in_ch.has_byte), .in_end(in_ch.end_of_message),
    .in_ready(in_ch.ready), .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .word_idx(idx), .stat, .cmd
  );

  // Datapath holds the block buffer, message schedule, chain and counters.
  shab_datapath u_dp (
    .clk, .rst_n, .cmd, .in_byte(in_ch.data_byte), .stat,
    .word_out(word), .word_idx(idx)
  );

  // Drive each digest beat straight from the chain registers.
  assign out_ch.digest_word = word;
  assign out_ch.word_index  = idx;
  assign out_ch.final_word  = (idx == 3'd7);

endmodule
